@@ rtl/mcg_pkg.sv @@
// ----------------------------------------------------------------------------
// mcg_pkg: shared types and constants of the midpoint circle generator
// Field widths, opcodes, register indexes and the job record that the front
// end hands to the back end.
// ----------------------------------------------------------------------------
package mcg_pkg;

   localparam int unsigned PX_W    = 10;
   localparam int unsigned PY_W    = 9;
   localparam int unsigned RAD_W   = 9;
   localparam int unsigned COLOR_W = 8;
   localparam int unsigned STEP_W  = 10;
   localparam int unsigned SCALE_W = STEP_W + 1;
   localparam int unsigned DEC_W   = 14;
   localparam int unsigned COORD_W = 13;
   localparam int unsigned CSR_W   = 10;
   localparam int unsigned CSR_IDX_W = 1;

   localparam int unsigned QUEUE_DEPTH_DEF = 2;

   localparam logic OP_START = 1'b0;
   localparam logic OP_TICK  = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_X_LIMIT = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_Y_LIMIT = 1'b1;

   localparam logic [PX_W-1:0] X_LIMIT_RST = 10'd719;
   localparam logic [PY_W-1:0] Y_LIMIT_RST = 9'd347;

   localparam logic [DEC_W-1:0] DEC_INIT    = 14'd3;
   localparam logic [DEC_W-1:0] DEC_INC_NEG = 14'd6;
   localparam logic [DEC_W-1:0] DEC_INC_POS = 14'd10;

   localparam logic [2:0] POINT_LAST = 3'd7;

   typedef struct packed {
      logic                 done;
      logic [PX_W-1:0]      cx;
      logic [PY_W-1:0]      cy;
      logic [STEP_W-1:0]    x;
      logic [STEP_W-1:0]    y;
      logic [SCALE_W-1:0]   sx;
      logic [SCALE_W-1:0]   sy;
      logic [COLOR_W-1:0]   color;
   } job_type;

endpackage

@@ rtl/midpoint_circle_generator_top.sv @@
// ----------------------------------------------------------------------------
// midpoint_circle_generator_top: midpoint circle generator
// Flow: a tick beat's results pass through the job queue and then the result
//   register; a start beat gives no result.
// Throughput: one result beat per cycle while results are popped, so eight
//   beats per plotting tick, set by the one-point-per-cycle back end.
// Reset: synchronous; clears the iterator to idle, empties the job queue and
//   the result register, and restores the screen limits to 719 by 347.
// ----------------------------------------------------------------------------
module midpoint_circle_generator_top import mcg_pkg::*; #(
   parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_push,
   output logic                 req_full,
   input  logic                 req_op,
   input  logic [PX_W-1:0]      req_center_x,
   input  logic [PY_W-1:0]      req_center_y,
   input  logic [RAD_W-1:0]     req_radius,
   input  logic [COLOR_W-1:0]   req_color,
   output logic                 rsp_empty,
   input  logic                 rsp_pop,
   output logic [PX_W-1:0]      rsp_pixel_x,
   output logic [PY_W-1:0]      rsp_pixel_y,
   output logic [COLOR_W-1:0]   rsp_pixel_value,
   output logic                 rsp_visible,
   output logic                 rsp_last,
   output logic                 rsp_done_res,
   input  logic                 csr_wr_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_W-1:0]     csr_wdata
);

   logic    q_push;
   logic    q_pop;
   logic    q_full;
   logic    q_empty;
   job_type q_job;
   job_type q_head;

   mcg_front u_front (
      .clock        (clock),
      .reset        (reset),
      .req_push     (req_push),
      .req_full     (req_full),
      .req_op       (req_op),
      .req_center_x (req_center_x),
      .req_center_y (req_center_y),
      .req_radius   (req_radius),
      .req_color    (req_color),
      .q_full       (q_full),
      .q_push       (q_push),
      .q_job        (q_job)
   );

   mcg_fifo #(
      .DEPTH (QUEUE_DEPTH)
   ) u_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_job (q_job),
      .pop      (q_pop),
      .full     (q_full),
      .empty    (q_empty),
      .head     (q_head)
   );

   mcg_back u_back (
      .clock           (clock),
      .reset           (reset),
      .csr_wr_en       (csr_wr_en),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .q_empty         (q_empty),
      .q_head          (q_head),
      .q_pop           (q_pop),
      .rsp_empty       (rsp_empty),
      .rsp_pop         (rsp_pop),
      .rsp_pixel_x     (rsp_pixel_x),
      .rsp_pixel_y     (rsp_pixel_y),
      .rsp_pixel_value (rsp_pixel_value),
      .rsp_visible     (rsp_visible),
      .rsp_last        (rsp_last),
      .rsp_done_res    (rsp_done_res)
   );

   a_reset_empty: assert property (@(posedge clock) reset |=> rsp_empty)
      else $error("result beat pending after reset");

   a_done_is_last: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_done_res) |-> (rsp_last && !rsp_visible))
      else $error("done beat not last or flagged visible");

   a_hidden_zero: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_visible) |-> (rsp_pixel_x == '0 && rsp_pixel_y == '0))
      else $error("hidden point carries coordinates");

   a_queue_ready: assert property (@(posedge clock) disable iff (reset)
      (q_push && !q_pop) |=> !q_empty)
      else $error("queued job lost");

endmodule

@@ rtl/mcg_front.sv @@
// ----------------------------------------------------------------------------
// mcg_front: request front end
// Accepts start and tick beats, runs the midpoint iterator state and queues
// one job per tick that produces results.
// ----------------------------------------------------------------------------
module mcg_front import mcg_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_push,
   output logic                 req_full,
   input  logic                 req_op,
   input  logic [PX_W-1:0]      req_center_x,
   input  logic [PY_W-1:0]      req_center_y,
   input  logic [RAD_W-1:0]     req_radius,
   input  logic [COLOR_W-1:0]   req_color,
   input  logic                 q_full,
   output logic                 q_push,
   output job_type              q_job
);

   logic [STEP_W-1:0]  step_x_ff, step_x_in;
   logic [STEP_W-1:0]  step_y_ff, step_y_in;
   logic [DEC_W-1:0]   dec_ff, dec_in;
   logic [PX_W-1:0]    cx_ff, cx_in;
   logic [PY_W-1:0]    cy_ff, cy_in;
   logic [COLOR_W-1:0] color_ff, color_in;
   logic               active_ff, active_in;

   logic accept;
   logic x_lt_y;
   logic x_eq_y;

   assign req_full = q_full;
   assign accept   = req_push && !q_full;
   assign x_lt_y   = step_x_ff < step_y_ff;
   assign x_eq_y   = step_x_ff == step_y_ff;

   always_comb begin
      q_job.done  = !active_ff;
      q_job.cx    = active_ff ? cx_ff : '0;
      q_job.cy    = active_ff ? cy_ff : '0;
      q_job.x     = step_x_ff;
      q_job.y     = step_y_ff;
      q_job.sx    = {1'b0, step_x_ff} + {2'b00, step_x_ff[STEP_W-1:1]};
      q_job.sy    = {1'b0, step_y_ff} + {2'b00, step_y_ff[STEP_W-1:1]};
      q_job.color = active_ff ? color_ff : '0;
   end

   assign q_push = accept && (req_op == OP_TICK) && (!active_ff || x_lt_y || x_eq_y);

   always_comb begin
      step_x_in = step_x_ff;
      step_y_in = step_y_ff;
      dec_in    = dec_ff;
      cx_in     = cx_ff;
      cy_in     = cy_ff;
      color_in  = color_ff;
      active_in = active_ff;
      if (accept) begin
         if (req_op == OP_START) begin
            cx_in     = req_center_x;
            cy_in     = req_center_y;
            color_in  = req_color;
            step_x_in = '0;
            step_y_in = STEP_W'(req_radius);
            dec_in    = DEC_INIT - DEC_W'({req_radius, 1'b0});
            active_in = 1'b1;
         end else if (active_ff) begin
            if (x_lt_y) begin
               // advance the iterator
               if (dec_ff[DEC_W-1]) begin
                  dec_in = dec_ff + DEC_W'({step_x_ff, 2'b00}) + DEC_INC_NEG;
               end else begin
                  dec_in = dec_ff + DEC_W'({step_x_ff, 2'b00})
                           - DEC_W'({step_y_ff, 2'b00}) + DEC_INC_POS;
                  step_y_in = step_y_ff - STEP_W'(1);
               end
               step_x_in = step_x_ff + STEP_W'(1);
            end else begin
               active_in = 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_x_ff <= '0;
         step_y_ff <= '0;
         dec_ff    <= '0;
         cx_ff     <= '0;
         cy_ff     <= '0;
         color_ff  <= '0;
         active_ff <= 1'b0;
      end else begin
         step_x_ff <= step_x_in;
         step_y_ff <= step_y_in;
         dec_ff    <= dec_in;
         cx_ff     <= cx_in;
         cy_ff     <= cy_in;
         color_ff  <= color_in;
         active_ff <= active_in;
      end
   end

endmodule

@@ rtl/mcg_fifo.sv @@
// ----------------------------------------------------------------------------
// mcg_fifo: job queue
// Short first-in first-out queue of jobs between the front and back ends.
// ----------------------------------------------------------------------------
module mcg_fifo import mcg_pkg::*; #(
   parameter int unsigned DEPTH = QUEUE_DEPTH_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type push_job,
   input  logic    pop,
   output logic    full,
   output logic    empty,
   output job_type head
);

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   job_type            mem_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_push;
   logic               do_pop;

   assign full    = count_ff == CNT_W'(DEPTH);
   assign empty   = count_ff == '0;
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign head    = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

@@ rtl/mcg_back.sv @@
// ----------------------------------------------------------------------------
// mcg_back: pixel back end
// Expands each queued job into its eight octant points, or one done beat,
// clips them against the screen limits and holds them in the result register.
// ----------------------------------------------------------------------------
module mcg_back import mcg_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_wr_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_W-1:0]     csr_wdata,
   input  logic                 q_empty,
   input  job_type              q_head,
   output logic                 q_pop,
   output logic                 rsp_empty,
   input  logic                 rsp_pop,
   output logic [PX_W-1:0]      rsp_pixel_x,
   output logic [PY_W-1:0]      rsp_pixel_y,
   output logic [COLOR_W-1:0]   rsp_pixel_value,
   output logic                 rsp_visible,
   output logic                 rsp_last,
   output logic                 rsp_done_res
);

   logic [PX_W-1:0]    x_limit_ff;
   logic [PY_W-1:0]    y_limit_ff;
   logic [2:0]         point_ff, point_in;
   logic               valid_ff, valid_in;
   logic [PX_W-1:0]    px_ff, px_in;
   logic [PY_W-1:0]    py_ff, py_in;
   logic [COLOR_W-1:0] value_ff, value_in;
   logic               vis_ff, vis_in;
   logic               last_ff, last_in;
   logic               done_ff, done_in;

   logic               advance;
   logic               swap;
   logic               neg_h;
   logic               neg_v;
   logic [SCALE_W-1:0] h_off;
   logic [STEP_W-1:0]  v_off;
   logic [COORD_W-1:0] px_full;
   logic [COORD_W-1:0] py_full;
   logic               in_x;
   logic               in_y;
   logic               job_last;

   assign advance = !valid_ff || rsp_pop;

   // octant order: swap on points 1,2,5,6; left half 4..7; upper rows 2..5
   assign swap  = point_ff[0] ^ point_ff[1];
   assign neg_h = point_ff[2];
   assign neg_v = point_ff[2] ^ point_ff[1];
   assign h_off = swap ? q_head.sy : q_head.sx;
   assign v_off = swap ? q_head.x  : q_head.y;

   assign px_full = neg_h ? (COORD_W'(q_head.cx) - COORD_W'(h_off))
                          : (COORD_W'(q_head.cx) + COORD_W'(h_off));
   assign py_full = neg_v ? (COORD_W'(q_head.cy) - COORD_W'(v_off))
                          : (COORD_W'(q_head.cy) + COORD_W'(v_off));

   assign in_x = (px_full[COORD_W-1:PX_W] == '0) && (px_full[PX_W-1:0] <= x_limit_ff);
   assign in_y = (py_full[COORD_W-1:PY_W] == '0) && (py_full[PY_W-1:0] <= y_limit_ff);

   assign job_last = q_head.done || (point_ff == POINT_LAST);
   assign q_pop    = advance && !q_empty && job_last;

   always_comb begin
      point_in = point_ff;
      valid_in = valid_ff;
      px_in    = px_ff;
      py_in    = py_ff;
      value_in = value_ff;
      vis_in   = vis_ff;
      last_in  = last_ff;
      done_in  = done_ff;
      if (advance) begin
         valid_in = !q_empty;
         if (!q_empty) begin
            point_in = job_last ? 3'd0 : point_ff + 3'd1;
            value_in = q_head.color;
            last_in  = job_last;
            done_in  = q_head.done;
            vis_in   = !q_head.done && in_x && in_y;
            px_in    = (!q_head.done && in_x && in_y) ? px_full[PX_W-1:0] : '0;
            py_in    = (!q_head.done && in_x && in_y) ? py_full[PY_W-1:0] : '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         point_ff <= '0;
         valid_ff <= 1'b0;
      end else begin
         point_ff <= point_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      px_ff    <= px_in;
      py_ff    <= py_in;
      value_ff <= value_in;
      vis_ff   <= vis_in;
      last_ff  <= last_in;
      done_ff  <= done_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         x_limit_ff <= X_LIMIT_RST;
         y_limit_ff <= Y_LIMIT_RST;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_X_LIMIT: x_limit_ff <= csr_wdata[PX_W-1:0];
            CSR_Y_LIMIT: y_limit_ff <= csr_wdata[PY_W-1:0];
            default: ;
         endcase
      end
   end

   assign rsp_empty       = !valid_ff;
   assign rsp_pixel_x     = px_ff;
   assign rsp_pixel_y     = py_ff;
   assign rsp_pixel_value = value_ff;
   assign rsp_visible     = vis_ff;
   assign rsp_last        = last_ff;
   assign rsp_done_res    = done_ff;

endmodule

@@ tb/midpoint_circle_generator_top_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// midpoint_circle_generator_top_tb: self-checking bench for the circle plotter
// Starts circles and steps them tick by tick while both queue sides stall at
// random. A scoreboard runs its own midpoint iterator on every accepted beat
// and matches each plotted pixel, in order, against the result queue. Screen
// limits are rewritten between phases while the block is idle.
// ----------------------------------------------------------------------------
module midpoint_circle_generator_top_tb import mcg_pkg::*; ;

   localparam int unsigned STALL_LIMIT = 2000;
   localparam int unsigned PHASES      = 5;
   localparam int unsigned PHASE_BEATS = 60;
   localparam int unsigned SETTLE_PAD  = 8;

   class pixel_scoreboard;
      typedef struct {
         logic [PX_W-1:0]    px;
         logic [PY_W-1:0]    py;
         logic [COLOR_W-1:0] value;
         logic               visible;
         logic               last;
         logic               done;
      } pixel_type;

      pixel_type               expected_pixels[$];
      logic [PX_W-1:0]         x_limit;
      logic [PY_W-1:0]         y_limit;
      logic [STEP_W-1:0]       step_x;
      logic [STEP_W-1:0]       step_y;
      logic signed [DEC_W-1:0] decision;
      logic [PX_W-1:0]         saved_cx;
      logic [PY_W-1:0]         saved_cy;
      logic [COLOR_W-1:0]      saved_color;
      bit                      active;
      int                      fails;

      function new();
         x_limit     = X_LIMIT_RST;
         y_limit     = Y_LIMIT_RST;
         step_x      = '0;
         step_y      = '0;
         decision    = '0;
         saved_cx    = '0;
         saved_cy    = '0;
         saved_color = '0;
         active      = 1'b0;
         fails       = 0;
      endfunction

      function void set_limit(logic [CSR_IDX_W-1:0] index, logic [CSR_W-1:0] value);
         if (index == CSR_X_LIMIT) begin
            x_limit = value[PX_W-1:0];
         end else begin
            y_limit = value[PY_W-1:0];
         end
      endfunction

      function int pending();
         return expected_pixels.size();
      endfunction

      function bit running();
         return active;
      endfunction

      function void put_point(int px, int py, bit is_last);
         pixel_type p;
         p.visible = (px >= 0 && px <= int'(x_limit) && py >= 0 && py <= int'(y_limit));
         p.px      = p.visible ? PX_W'(px) : '0;
         p.py      = p.visible ? PY_W'(py) : '0;
         p.value   = saved_color;
         p.last    = is_last;
         p.done    = 1'b0;
         expected_pixels.push_back(p);
      endfunction

      function void plot_octants();
         int cx, cy, x, y, sx, sy;
         cx = int'(saved_cx);
         cy = int'(saved_cy);
         x  = int'(step_x);
         y  = int'(step_y);
         sx = x + (x >> 1);
         sy = y + (y >> 1);
         put_point(cx + sx, cy + y, 1'b0);
         put_point(cx + sy, cy + x, 1'b0);
         put_point(cx + sy, cy - x, 1'b0);
         put_point(cx + sx, cy - y, 1'b0);
         put_point(cx - sx, cy - y, 1'b0);
         put_point(cx - sy, cy - x, 1'b0);
         put_point(cx - sy, cy + x, 1'b0);
         put_point(cx - sx, cy + y, 1'b1);
      endfunction

      function void note_request(logic op, logic [PX_W-1:0] cx, logic [PY_W-1:0] cy,
                                 logic [RAD_W-1:0] radius, logic [COLOR_W-1:0] color);
         int        d;
         pixel_type p;
         if (op == OP_START) begin
            saved_cx    = cx;
            saved_cy    = cy;
            saved_color = color;
            step_x      = '0;
            step_y      = STEP_W'(radius);
            decision    = DEC_W'(3 - 2 * int'(radius));
            active      = 1'b1;
         end else if (!active) begin
            p         = '{default: '0};
            p.last    = 1'b1;
            p.done    = 1'b1;
            expected_pixels.push_back(p);
         end else if (step_x < step_y) begin
            plot_octants();
            d = int'(decision);
            if (d < 0) begin
               d = d + 4 * int'(step_x) + 6;
            end else begin
               d = d + 4 * (int'(step_x) - int'(step_y)) + 10;
               step_y = step_y - 1'b1;
            end
            step_x   = step_x + 1'b1;
            decision = DEC_W'(d);
         end else begin
            active = 1'b0;
            if (step_x == step_y) plot_octants();
         end
      endfunction

      task report(string what);
         fails++;
         if (fails <= 100) $display("%0t: %s", $time, what);
      endtask

      task compare_field(string name, logic [15:0] want, logic [15:0] got);
         if (got !== want) report($sformatf("%s: expected %0d, got %0d", name, want, got));
      endtask

      task check_pixel(logic [PX_W-1:0] px, logic [PY_W-1:0] py, logic [COLOR_W-1:0] value,
                       logic visible, logic last, logic done);
         pixel_type want;
         if (expected_pixels.size() == 0) begin
            report("result beat with nothing expected");
         end else begin
            want = expected_pixels.pop_front();
            compare_field("pixel_x", want.px, px);
            compare_field("pixel_y", want.py, py);
            compare_field("pixel_value", want.value, value);
            compare_field("visible", want.visible, visible);
            compare_field("last", want.last, last);
            compare_field("done_res", want.done, done);
         end
      endtask
   endclass

   logic                 clock        = 1'b0;
   logic                 reset        = 1'b1;
   logic                 req_push     = 1'b0;
   logic                 req_full;
   logic                 req_op       = OP_START;
   logic [PX_W-1:0]      req_center_x = '0;
   logic [PY_W-1:0]      req_center_y = '0;
   logic [RAD_W-1:0]     req_radius   = '0;
   logic [COLOR_W-1:0]   req_color    = '0;
   logic                 rsp_empty;
   logic                 rsp_pop      = 1'b0;
   logic [PX_W-1:0]      rsp_pixel_x;
   logic [PY_W-1:0]      rsp_pixel_y;
   logic [COLOR_W-1:0]   rsp_pixel_value;
   logic                 rsp_visible;
   logic                 rsp_last;
   logic                 rsp_done_res;
   logic                 csr_wr_en    = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index    = CSR_X_LIMIT;
   logic [CSR_W-1:0]     csr_wdata    = '0;

   pixel_scoreboard sb = new();

   int unsigned beats_sent  = 0;
   int unsigned idle_cycles = 0;
   int          stall_left  = 0;
   int          calm_left   = 0;
   bit          no_idling   = 1'b0;
   bit          calm        = 1'b0;

   midpoint_circle_generator_top dut (.*);

   always #2 clock = ~clock;

   // pop side: random stall bursts, with calm stretches in between
   always @(posedge clock) begin
      if (reset) begin
         rsp_pop    <= 1'b0;
         stall_left <= 0;
         calm_left  <= 0;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_pop    <= 1'b0;
      end else if (no_idling || calm_left > 0) begin
         rsp_pop <= 1'b1;
         if (calm_left > 0) calm_left <= calm_left - 1;
      end else if ($urandom_range(0, 4) == 0) begin
         rsp_pop    <= 1'b0;
         stall_left <= $urandom_range(0, 9);
      end else begin
         rsp_pop <= 1'b1;
         if ($urandom_range(0, 19) == 0) calm_left <= $urandom_range(20, 80);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_pop && !rsp_empty) begin
         sb.check_pixel(rsp_pixel_x, rsp_pixel_y, rsp_pixel_value, rsp_visible, rsp_last,
                        rsp_done_res);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_push && !req_full) || (rsp_pop && !rsp_empty) || csr_wr_en) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles + 1 >= STALL_LIMIT) begin
            $display("** midpoint_circle_generator_top: FAILED **");
            $finish;
         end
      end
   end

   task push_beat(logic op, logic [PX_W-1:0] cx, logic [PY_W-1:0] cy,
                  logic [RAD_W-1:0] radius, logic [COLOR_W-1:0] color);
      if (!no_idling && !calm && $urandom_range(0, 3) == 0) begin
         req_push <= 1'b0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
      end
      req_push     <= 1'b1;
      req_op       <= op;
      req_center_x <= cx;
      req_center_y <= cy;
      req_radius   <= radius;
      req_color    <= color;
      do @(posedge clock); while (req_full);
      sb.note_request(op, cx, cy, radius, color);
      beats_sent++;
   endtask

   task push_tick();
      push_beat(OP_TICK, PX_W'($urandom), PY_W'($urandom), RAD_W'($urandom),
                COLOR_W'($urandom));
   endtask

   task drive_circle(logic [PX_W-1:0] cx, logic [PY_W-1:0] cy, logic [RAD_W-1:0] radius,
                     logic [COLOR_W-1:0] color, int max_ticks, bit closing_tick);
      int n;
      n = 0;
      push_beat(OP_START, cx, cy, radius, color);
      while (sb.running() && n < max_ticks) begin
         push_tick();
         n++;
      end
      if (closing_tick) push_tick();
   endtask

   // hold the sender until every pixel is back, then let stray work finish
   task settle_results();
      req_push <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (SETTLE_PAD) @(posedge clock);
   endtask

   task write_limits(logic [CSR_W-1:0] x_value, logic [CSR_W-1:0] y_value);
      csr_wr_en <= 1'b1;
      csr_index <= CSR_X_LIMIT;
      csr_wdata <= x_value;
      @(posedge clock);
      sb.set_limit(CSR_X_LIMIT, x_value);
      csr_index <= CSR_Y_LIMIT;
      csr_wdata <= y_value;
      @(posedge clock);
      sb.set_limit(CSR_Y_LIMIT, y_value);
      csr_wr_en <= 1'b0;
   endtask

   task random_stretch();
      logic [PX_W-1:0]  cx;
      logic [PY_W-1:0]  cy;
      logic [RAD_W-1:0] radius;
      int               cap;
      calm = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 9) == 0) begin
         push_beat(($urandom_range(0, 1) == 1) ? OP_TICK : OP_START, PX_W'($urandom),
                   PY_W'($urandom), RAD_W'($urandom), COLOR_W'($urandom));
      end else begin
         if ($urandom_range(0, 1) == 1) begin
            cx = PX_W'($urandom_range(0, sb.x_limit));
            cy = PY_W'($urandom_range(0, sb.y_limit));
         end else begin
            cx = PX_W'($urandom);
            cy = PY_W'($urandom);
         end
         radius = ($urandom_range(0, 15) == 0) ? RAD_W'($urandom_range(256, 511))
                                               : RAD_W'($urandom_range(0, 40));
         cap    = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 3) : 40;
         drive_circle(cx, cy, radius, COLOR_W'($urandom), cap, $urandom_range(0, 1) == 1);
      end
      if ($urandom_range(0, 29) == 0) settle_results();
   endtask

   initial begin
      int unsigned phase_end;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      push_tick();
      drive_circle(10'd0, 9'd0, 9'd0, 8'hFF, 100, 1'b1);
      drive_circle(10'd1023, 9'd511, 9'd1, 8'h00, 100, 1'b1);
      drive_circle(10'd360, 9'd170, 9'd511, 8'hA5, 2, 1'b0);
      drive_circle(10'd100, 9'd100, 9'd3, 8'h5A, 100, 1'b1);
      drive_circle(10'd0, 9'd511, 9'd511, 8'h0F, 1, 1'b0);
      drive_circle(10'd1023, 9'd0, 9'd2, 8'hF0, 100, 1'b1);
      settle_results();

      for (int phase = 0; phase < PHASES; phase++) begin
         case (phase)
            0: write_limits(10'h3FF, 10'h3FF);
            1: write_limits(10'h000, 10'h000);
            2, 3: write_limits(CSR_W'($urandom), CSR_W'($urandom));
            default: begin
               write_limits(CSR_W'(X_LIMIT_RST), CSR_W'(Y_LIMIT_RST));
               no_idling = 1'b1;
            end
         endcase
         phase_end = beats_sent + PHASE_BEATS;
         while (beats_sent < phase_end) random_stretch();
         settle_results();
      end

      repeat (16) @(posedge clock);
      if (sb.fails == 0 && sb.pending() == 0) begin
         $display("** midpoint_circle_generator_top: PASSED **");
      end else begin
         $display("** midpoint_circle_generator_top: FAILED **");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
rtl/mcg_pkg.sv
rtl/mcg_front.sv
rtl/mcg_fifo.sv
rtl/mcg_back.sv
rtl/midpoint_circle_generator_top.sv
tb/midpoint_circle_generator_top_tb.sv
